[rtl/bls_pkg.sv]
// Shared types and constants for the Bresenham line pixel sum block.
`default_nettype none
package bls_pkg;

    localparam int unsigned IMAGE_WIDTH_DEF  = 256;
    localparam int unsigned IMAGE_HEIGHT_DEF = 256;

    localparam int unsigned COORD_W = 8;
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned SUM_W   = 16;
    localparam int unsigned SPAN2_W = COORD_W + 1;
    localparam int unsigned ERR_W   = COORD_W + 3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/bls_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bls_ram #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH   = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [DATA_W-1:0]        wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/bresenham_line_pixel_sum_top.sv]
// Top level: image store and Bresenham line walker that sums pixels on a line.
// A load item is written to the image store as it is accepted.
// A score item whose major span is D walks N = D + 1 pixels (1 to 256), one
// image store read per cycle; the sum goes to the result register in done.
// No item is taken during walk, drain and done; done stalls while a result waits.
// aresetn clears the control state; image contents stay undefined until loaded.
`default_nettype none
module bresenham_line_pixel_sum_top
    import bls_pkg::*;
#(
    parameter int unsigned IMAGE_WIDTH  = IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = IMAGE_HEIGHT_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_command,
    input  wire logic [COORD_W-1:0] s_pixel_col,
    input  wire logic [COORD_W-1:0] s_pixel_row,
    input  wire logic [PIX_W-1:0]   s_pixel_value,
    input  wire logic [COORD_W-1:0] s_start_col,
    input  wire logic [COORD_W-1:0] s_start_row,
    input  wire logic [COORD_W-1:0] s_end_col,
    input  wire logic [COORD_W-1:0] s_end_row,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [SUM_W-1:0]   m_line_sum
);

    localparam int unsigned COORD_SPAN = 1 << COORD_W;
    localparam int unsigned COLS   = (IMAGE_WIDTH  < COORD_SPAN) ? IMAGE_WIDTH  : COORD_SPAN;
    localparam int unsigned ROWS   = (IMAGE_HEIGHT < COORD_SPAN) ? IMAGE_HEIGHT : COORD_SPAN;
    localparam int unsigned COL_AW = $clog2(COLS);
    localparam int unsigned ROW_AW = $clog2(ROWS);
    localparam int unsigned ADDR_W = COL_AW + ROW_AW;
    localparam int unsigned DEPTH  = 1 << ADDR_W;

    state_t state_reg, state_next;

    logic                       steep_reg;
    logic                       step_up_reg;
    logic [COORD_W-1:0]         major_reg;
    logic [COORD_W-1:0]         minor_reg;
    logic [COORD_W-1:0]         maj_end_reg;
    logic [SPAN2_W-1:0]         dmin2_reg;
    logic [SPAN2_W-1:0]         dmaj2_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic                       rd_vld_reg;
    logic                       rd_inb_reg;
    logic                       m_valid_reg;
    logic [SUM_W-1:0]           m_sum_reg;

    logic                       accept;
    logic                       walk_en;
    logic                       result_load;
    logic                       wr_en;
    logic                       wr_inb;
    logic [ADDR_W-1:0]          waddr;
    logic [ADDR_W-1:0]          raddr;
    logic [PIX_W-1:0]           rdata;

    logic [COORD_W-1:0]         span_c, span_r, a1, b1, a2, b2;
    logic [COORD_W-1:0]         maj1, min1, maj2, min2;
    logic                       steep, swap;
    logic [COORD_W-1:0]         cur_col, cur_row;
    logic                       cur_inb;
    logic signed [ERR_W-1:0]    err_dec;
    logic                       last_px;

    assign accept = s_valid && s_ready;

    // Line setup from the endpoints of a score item.
    always_comb begin
        span_c = (s_start_col > s_end_col) ? s_start_col - s_end_col : s_end_col - s_start_col;
        span_r = (s_start_row > s_end_row) ? s_start_row - s_end_row : s_end_row - s_start_row;
        steep  = span_r > span_c;
        a1     = steep ? s_start_row : s_start_col;
        b1     = steep ? s_start_col : s_start_row;
        a2     = steep ? s_end_row   : s_end_col;
        b2     = steep ? s_end_col   : s_end_row;
        swap   = a1 > a2;
        maj1   = swap ? a2 : a1;
        min1   = swap ? b2 : b1;
        maj2   = swap ? a1 : a2;
        min2   = swap ? b1 : b2;
    end

    // Walk step.
    always_comb begin
        cur_col = steep_reg ? minor_reg : major_reg;
        cur_row = steep_reg ? major_reg : minor_reg;
        cur_inb = ({{(32-COORD_W){1'b0}}, cur_col} < 32'(IMAGE_WIDTH))
               && ({{(32-COORD_W){1'b0}}, cur_row} < 32'(IMAGE_HEIGHT));
        err_dec = err_reg - signed'({{(ERR_W-SPAN2_W){1'b0}}, dmin2_reg});
        last_px = major_reg == maj_end_reg;
        raddr   = {cur_row[ROW_AW-1:0], cur_col[COL_AW-1:0]};
    end

    assign wr_inb = ({{(32-COORD_W){1'b0}}, s_pixel_col} < 32'(IMAGE_WIDTH))
                 && ({{(32-COORD_W){1'b0}}, s_pixel_row} < 32'(IMAGE_HEIGHT));
    assign wr_en  = accept && (s_command == CMD_LOAD) && wr_inb;
    assign waddr  = {s_pixel_row[ROW_AW-1:0], s_pixel_col[COL_AW-1:0]};

    bls_ram #(
        .DATA_W(PIX_W),
        .DEPTH (DEPTH)
    ) u_image (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(waddr),
        .wdata(s_pixel_value),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_command == CMD_SCORE)) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (last_px) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: state_next = S_DONE;
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        walk_en     = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            S_IDLE:  s_ready = 1'b1;
            S_WALK:  walk_en = 1'b1;
            S_DRAIN: ;
            S_DONE:  result_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= walk_en;
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_inb_reg <= cur_inb;
        if (accept && (s_command == CMD_SCORE)) begin
            steep_reg   <= steep;
            step_up_reg <= min2 > min1;
            major_reg   <= maj1;
            minor_reg   <= min1;
            maj_end_reg <= maj2;
            dmin2_reg   <= {(steep ? span_c : span_r), 1'b0};
            dmaj2_reg   <= {(steep ? span_r : span_c), 1'b0};
            err_reg     <= signed'(ERR_W'(steep ? span_r : span_c));
            sum_reg     <= '0;
        end else begin
            if (walk_en) begin
                major_reg <= major_reg + 1'b1;
                if (err_dec < 0) begin
                    minor_reg <= step_up_reg ? minor_reg + 1'b1 : minor_reg - 1'b1;
                    err_reg   <= err_dec + signed'({{(ERR_W-SPAN2_W){1'b0}}, dmaj2_reg});
                end else begin
                    err_reg <= err_dec;
                end
            end
            if (rd_vld_reg && rd_inb_reg) begin
                sum_reg <= sum_reg + {{(SUM_W-PIX_W){1'b0}}, rdata};
            end
        end
        if (result_load) begin
            m_sum_reg <= sum_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_line_sum = m_sum_reg;

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg == S_IDLE)
        else $error("image write outside idle");

    a_score_walks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_SCORE) |=> state_reg == S_WALK)
        else $error("score item did not start a walk");

    a_walk_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |=> rd_vld_reg && (state_reg == S_WALK || state_reg == S_DRAIN))
        else $error("walk read pipeline out of step");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

endmodule
`default_nettype wire

[sim/tb_bresenham_line_pixel_sum_top.sv]
// Testbench for the line pixel sum block: directed table, then random loads and line scores.
module tb_bresenham_line_pixel_sum_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bls_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 10;
    localparam int RAND_ITEMS    = 480;
    localparam int PHASES        = 5;
    localparam int WIN_COL       = 96;
    localparam int WIN_ROW       = 64;
    localparam int WIN_SIZE      = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 300;
    localparam int DIRECTED_ROWS = 23;

    typedef logic [15:0] addr_q_t[$];

    typedef struct {
        logic             cmd;
        logic [7:0]       pcol, prow, pval, scol, srow, ecol, erow;
        int               fill;
        bit               typed;
        logic [SUM_W-1:0] want;
    } step_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic [COORD_W-1:0] s_pixel_col;
    logic [COORD_W-1:0] s_pixel_row;
    logic [PIX_W-1:0]   s_pixel_value;
    logic [COORD_W-1:0] s_start_col;
    logic [COORD_W-1:0] s_start_row;
    logic [COORD_W-1:0] s_end_col;
    logic [COORD_W-1:0] s_end_row;
    logic               m_valid;
    logic               m_ready;
    logic [SUM_W-1:0]   m_line_sum;

    logic [PIX_W-1:0]   image_copy [0:65535];
    bit                 pixel_loaded [0:65535];
    logic [SUM_W-1:0]   expected_sums [$];
    int                 items_accepted = 0;
    int                 fail_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_req = 0;
    int                 hold_left = 0;

    step_t directed [DIRECTED_ROWS] = '{
        '{CMD_LOAD,    0,   0, 8'h00,   0,   0,   0,   0,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,   0,   0,   0,   0,  -1, 1'b1, 16'd0},
        '{CMD_LOAD,  255, 255, 8'hFF,   0,   0,   0,   0,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0, 255, 255, 255, 255,  -1, 1'b1, 16'd255},
        '{CMD_LOAD,  255,   0, 8'hA5,   0,   0,   0,   0,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0, 255,   0, 255,   0,  -1, 1'b1, 16'h00A5},
        '{CMD_LOAD,    0, 255, 8'h5A,   0,   0,   0,   0,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,   0, 255,   0, 255,  -1, 1'b1, 16'h005A},
        '{CMD_SCORE,   0,   0,     0,   0, 128, 255, 128, 255, 1'b1, 16'd65280},
        '{CMD_SCORE,   0,   0,     0, 255, 128,   0, 128,  -1, 1'b1, 16'd65280},
        '{CMD_SCORE,   0,   0,     0,   0,   0,   3,   1,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0, 255, 255, 250, 253,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,   0, 255,   2, 250,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0, 255,   0, 252,   3,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,  10,  20,  30,  25,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,  30,  25,  10,  20,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,  10,  20,  15,  60,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,  40,  10,  30,  50,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0, 100, 100, 110,  90,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,   7,   3,   7,   9,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,  20, 200,  21, 255,  -1, 1'b0, 16'd0},
        '{CMD_LOAD,    0,   0, 8'hFF,   0,   0,   0,   0,  -1, 1'b0, 16'd0},
        '{CMD_SCORE,   0,   0,     0,   0,   0,   0,   0,  -1, 1'b1, 16'd255}
    };

    bresenham_line_pixel_sum_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_pixel_col   (s_pixel_col),
        .s_pixel_row   (s_pixel_row),
        .s_pixel_value (s_pixel_value),
        .s_start_col   (s_start_col),
        .s_start_row   (s_start_row),
        .s_end_col     (s_end_col),
        .s_end_row     (s_end_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_sum    (m_line_sum)
    );

    initial aclk = 1'b0;
    always #(HALF_PERIOD) aclk = ~aclk;

    initial begin
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #(20_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // Pixel addresses of the line walk, row in the upper byte.
    function automatic void line_pixels(input int c1, r1, c2, r2, output addr_q_t pts);
        int  maj_a, min_a, maj_b, min_b, tmp, dmaj, dmin, err, dir, minor;
        bit  steep;
        pts = {};
        steep = ((r1 > r2) ? r1 - r2 : r2 - r1) > ((c1 > c2) ? c1 - c2 : c2 - c1);
        if (steep) begin
            maj_a = r1; min_a = c1; maj_b = r2; min_b = c2;
        end else begin
            maj_a = c1; min_a = r1; maj_b = c2; min_b = r2;
        end
        if (maj_a > maj_b) begin
            tmp = maj_a; maj_a = maj_b; maj_b = tmp;
            tmp = min_a; min_a = min_b; min_b = tmp;
        end
        dmaj  = maj_b - maj_a;
        dmin  = (min_b > min_a) ? min_b - min_a : min_a - min_b;
        err   = dmaj;
        dir   = (min_a < min_b) ? 1 : -1;
        minor = min_a;
        for (int major = maj_a; major <= maj_b; major++) begin
            if (steep)
                pts.push_back({8'(major), 8'(minor)});
            else
                pts.push_back({8'(minor), 8'(major)});
            err -= 2 * dmin;
            if (err < 0) begin
                minor += dir;
                err   += 2 * dmaj;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
                                   input logic [SUM_W-1:0] want);
        $display("%0t ns: %s: line_sum got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] pcol, prow, pval,
                             input logic [7:0] scol, srow, ecol, erow,
                             input bit typed = 1'b0, input logic [SUM_W-1:0] want = '0);
        addr_q_t     pts;
        int unsigned acc;
        if (cmd == CMD_LOAD) begin
            scol = 8'($urandom); srow = 8'($urandom);
            ecol = 8'($urandom); erow = 8'($urandom);
        end else begin
            pcol = 8'($urandom); prow = 8'($urandom); pval = 8'($urandom);
        end
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_pixel_col   <= pcol;
        s_pixel_row   <= prow;
        s_pixel_value <= pval;
        s_start_col   <= scol;
        s_start_row   <= srow;
        s_end_col     <= ecol;
        s_end_row     <= erow;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_LOAD) begin
            image_copy[{prow, pcol}]   = pval;
            pixel_loaded[{prow, pcol}] = 1'b1;
        end else if (typed) begin
            expected_sums.push_back(want);
        end else begin
            line_pixels(scol, srow, ecol, erow, pts);
            acc = 0;
            foreach (pts[i]) acc += image_copy[pts[i]];
            expected_sums.push_back(SUM_W'(acc));
        end
        items_accepted++;
        @(negedge aclk);
    endtask

    // Load every pixel of the line not yet written, then score it.
    task automatic score_line(input int c1, r1, c2, r2, input int fill, input bit typed,
                              input logic [SUM_W-1:0] want);
        addr_q_t pts;
        line_pixels(c1, r1, c2, r2, pts);
        foreach (pts[i]) begin
            if (!pixel_loaded[pts[i]])
                send_item(CMD_LOAD, pts[i][7:0], pts[i][15:8],
                          (fill < 0) ? 8'($urandom) : 8'(fill), 0, 0, 0, 0);
        end
        send_item(CMD_SCORE, 0, 0, 0, 8'(c1), 8'(r1), 8'(c2), 8'(r2), typed, want);
    endtask

    task automatic random_item(input bit score_only);
        int pick, c1, r1, c2, r2, reach;
        pick = $urandom_range(99);
        if (!score_only && pick < 10) begin
            send_item(CMD_LOAD, 8'(WIN_COL + $urandom_range(WIN_SIZE - 1)),
                      8'(WIN_ROW + $urandom_range(WIN_SIZE - 1)), 8'($urandom), 0, 0, 0, 0);
        end else if (!score_only && pick < 20) begin
            send_item(CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), 0, 0, 0, 0);
        end else begin
            pick = $urandom_range(199);
            if (pick < 3) begin
                c1 = $urandom_range(255); r1 = $urandom_range(255);
                c2 = $urandom_range(255); r2 = $urandom_range(255);
            end else if (pick < 110) begin
                c1 = WIN_COL + $urandom_range(WIN_SIZE - 1);
                r1 = WIN_ROW + $urandom_range(WIN_SIZE - 1);
                c2 = WIN_COL + $urandom_range(WIN_SIZE - 1);
                r2 = WIN_ROW + $urandom_range(WIN_SIZE - 1);
            end else begin
                reach = $urandom_range(12, 1);
                c1 = $urandom_range(255);
                r1 = $urandom_range(255);
                c2 = $urandom_range((c1 + reach < 255) ? c1 + reach : 255,
                                    (c1 > reach) ? c1 - reach : 0);
                r2 = $urandom_range((r1 + reach < 255) ? r1 + reach : 255,
                                    (r1 > reach) ? r1 - reach : 0);
            end
            score_line(c1, r1, c2, r2, -1, 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_sums.size() != 0) @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0)
                report_mismatch("result with nothing pending", m_line_sum, '0);
            else if (m_line_sum !== expected_sums[0])
                report_mismatch("wrong sum", m_line_sum, expected_sums.pop_front());
            else
                void'(expected_sums.pop_front());
        end
    end

    initial begin
        int base;
        s_valid       = 1'b0;
        s_command     = CMD_LOAD;
        s_pixel_col   = '0;
        s_pixel_row   = '0;
        s_pixel_value = '0;
        s_start_col   = '0;
        s_start_row   = '0;
        s_end_col     = '0;
        s_end_row     = '0;
        wait (aresetn == 1'b1);
        @(negedge aclk);

        foreach (directed[i]) begin
            if (directed[i].cmd == CMD_LOAD)
                send_item(CMD_LOAD, directed[i].pcol, directed[i].prow, directed[i].pval,
                          0, 0, 0, 0);
            else
                score_line(directed[i].scol, directed[i].srow, directed[i].ecol,
                           directed[i].erow, directed[i].fill, directed[i].typed,
                           directed[i].want);
        end
        drain_results();

        base = items_accepted;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == PHASES - 1) begin
                hold_req = HOLD_CYCLES;
                repeat (8) random_item(1'b1);
            end
            while (items_accepted < base + (ph + 1) * RAND_ITEMS / PHASES)
                random_item(1'b0);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
